// ===== design/dpcm_enc_pkg.sv =====
package dpcm_enc_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT    = 1024;

  // reciprocal of the doubled step, scaled by 2^RECIP_SHIFT
  localparam int RECIP_SHIFT = 11;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  typedef logic signed [9:0]  recon_t;
  typedef logic signed [10:0] diff_t;

  localparam diff_t MID_LEVEL = 11'sd128;

  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_STEP   = 3'd1;
  localparam logic [2:0] CFG_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_HEIGHT = 3'd3;

  localparam logic [1:0] MODE_LEFT  = 2'd0;
  localparam logic [1:0] MODE_AVG   = 2'd1;
  localparam logic [1:0] MODE_ADAPT = 2'd2;
  localparam logic [1:0] MODE_COMP  = 2'd3;

endpackage

// ===== design/dpcm_image_encoder_core.sv =====
// Channel  Ports                                        Direction
// cfg      cfg_we, cfg_index, cfg_wdata                 in
// in       in_valid, in_stall, in_pixel_value           in
// out      out_valid, out_stall, out_coded_value,       out
//          out_chosen_predictor, out_reconstructed_value, out_frame_end
// A pixel passes through line memory read, prediction, reciprocal multiply,
// quotient correction, reconstruction and write-back; the next pixel needs it.
// A quant_step write starts a reciprocal computation; in_stall is high meanwhile.
// Reset is synchronous; the line memory is not cleared.
// A result waiting under out_stall holds the last stage, not the input side.
module dpcm_image_encoder_core
  import dpcm_enc_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [10:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_pixel_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [9:0] out_coded_value,
  output logic [1:0]        out_chosen_predictor,
  output logic signed [9:0] out_reconstructed_value,
  output logic              out_frame_end
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = (AW > 11 ? AW : 11) + 1;
  localparam int RC_CW = $clog2(RECIP_W);
  localparam logic [CW-1:0]      MAX_W_C   = CW'(MAX_WIDTH);
  localparam logic [11:0]        MAX_H_C   = 12'(MAX_HEIGHT);
  localparam logic [RECIP_W-1:0] RECIP_RST = RECIP_W'(1) << (RECIP_SHIFT - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRED = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_CORR = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  function automatic logic [10:0] abs11(input diff_t v);
    abs11 = v[10] ? 11'(-v) : 11'(v);
  endfunction

  logic [1:0]  mode_r;
  logic [7:0]  step_r;
  logic [10:0] width_r;
  logic [10:0] height_r;

  logic [2:0]    state_r;
  logic [AW-1:0] col_r;
  logic [9:0]    row_r;
  recon_t        left_r;
  recon_t        upleft_r;
  logic [7:0]    px_r;
  recon_t        up_r;
  recon_t        pred_r;
  logic [1:0]    choice_r;
  logic [9:0]    m_r;
  logic          neg_r;
  logic [9:0]    qa_r;
  diff_t         q_r;
  logic          out_valid_r;

  logic [9:0] line_mem [MAX_WIDTH];

  logic               rc_busy_r;
  logic [RC_CW-1:0]   rc_cnt_r;
  logic [8:0]         rc_rem_r;
  logic [RECIP_W-1:0] rc_quo_r;
  logic [RECIP_W-1:0] recip_r;
  logic [8:0]         rc_rem_nxt;
  logic               rc_bit;
  logic [9:0]         rc_trial;
  logic               rc_start;

  logic       accept;
  logic       out_free;
  logic       fin_fire;
  logic [7:0] s_eff;
  logic [8:0] dvs;

  // ---------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_LEFT;
      step_r   <= 8'd1;
      width_r  <= 11'd1024;
      height_r <= 11'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_wdata[1:0];
        CFG_STEP:   step_r   <= cfg_wdata[7:0];
        CFG_WIDTH:  width_r  <= cfg_wdata;
        CFG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s_eff    = (step_r == 8'd0) ? 8'd1 : step_r;
  assign dvs      = {s_eff, 1'b0};
  assign rc_start = cfg_we && (cfg_index == CFG_STEP);

  // ---------------- reciprocal of 2*step, restoring, one bit per cycle
  always_comb begin
    rc_trial = {rc_rem_r, (rc_cnt_r == '0)};
    if (rc_trial >= {1'b0, dvs}) begin
      rc_rem_nxt = 9'(rc_trial - {1'b0, dvs});
      rc_bit     = 1'b1;
    end else begin
      rc_rem_nxt = rc_trial[8:0];
      rc_bit     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_busy_r <= 1'b0;
      rc_cnt_r  <= '0;
      recip_r   <= RECIP_RST;
    end else if (rc_start) begin
      rc_busy_r <= 1'b1;
      rc_cnt_r  <= '0;
      rc_rem_r  <= '0;
      rc_quo_r  <= '0;
    end else if (rc_busy_r) begin
      rc_rem_r <= rc_rem_nxt;
      rc_quo_r <= {rc_quo_r[RECIP_W-2:0], rc_bit};
      rc_cnt_r <= rc_cnt_r + RC_CW'(1);
      if (rc_cnt_r == RC_CW'(RECIP_W - 1)) begin
        rc_busy_r <= 1'b0;
        recip_r   <= {rc_quo_r[RECIP_W-2:0], rc_bit};
      end
    end
  end

  // ---------------- handshake
  assign in_stall  = (state_r != ST_IDLE) || rc_busy_r || rc_start;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign fin_fire  = (state_r == ST_FIN) && out_free;
  assign out_valid = out_valid_r;

  // ---------------- prediction
  logic       first_row;
  logic       first_col;
  diff_t      x11, up11, l11, d11;
  diff_t      p_left, p_avg, p_adapt, pred;
  diff_t      avg_a, avg_b, avg_sum;
  diff_t      e_pred;
  logic [10:0] a0, a1, a2;
  logic [1:0]  choice;
  logic signed [11:0] n12;
  logic [11:0] n_mag;

  always_comb begin
    first_row = (row_r == '0);
    first_col = (col_r == '0);
    x11  = {3'b000, px_r};
    up11 = {up_r[9], up_r};
    l11  = {left_r[9], left_r};
    d11  = {upleft_r[9], upleft_r};

    p_left  = first_col ? MID_LEVEL : l11;
    avg_a   = first_col ? MID_LEVEL : l11;
    avg_b   = first_row ? MID_LEVEL : up11;
    avg_sum = avg_a + avg_b;
    p_avg   = (avg_sum + diff_t'({10'b0, avg_sum[10]})) >>> 1;

    priority if (first_row && first_col) p_adapt = MID_LEVEL;
    else if (first_row)                  p_adapt = l11;
    else if (first_col)                  p_adapt = up11;
    else if (abs11(up11 - d11) < abs11(l11 - d11)) p_adapt = l11;
    else                                 p_adapt = up11;

    a0 = abs11(x11 - p_left);
    a1 = abs11(x11 - p_avg);
    a2 = abs11(x11 - p_adapt);

    if (mode_r == MODE_COMP) begin
      priority if (a0 < a1 && a0 < a2) choice = MODE_LEFT;
      else if (a1 < a2)                choice = MODE_AVG;
      else                             choice = MODE_ADAPT;
    end else begin
      choice = mode_r;
    end

    unique case (choice)
      MODE_LEFT: pred = p_left;
      MODE_AVG:  pred = p_avg;
      default:   pred = p_adapt;
    endcase

    e_pred = x11 - pred;
    n12    = {e_pred, 1'b0} + {4'b0000, s_eff};
    n_mag  = n12[11] ? 12'(-n12) : 12'(n12);
  end

  // ---------------- quotient via reciprocal
  logic [RECIP_W+9:0] prod;
  logic [18:0] qd;
  logic [9:0]  r10;
  logic        ge;
  logic [9:0]  qm;
  logic        rnz;
  logic [10:0] qmag;
  diff_t       q_nxt;

  assign prod = {{RECIP_W{1'b0}}, m_r} * {10'b0, recip_r};

  always_comb begin
    qd    = {9'b0, qa_r} * {10'b0, dvs};
    r10   = m_r - qd[9:0];
    ge    = r10 >= {1'b0, dvs};
    qm    = qa_r + {9'b0, ge};
    rnz   = ge ? (r10 != {1'b0, dvs}) : (r10 != 10'd0);
    qmag  = {1'b0, qm} + {10'b0, (neg_r && rnz)};
    q_nxt = neg_r ? diff_t'(-qmag) : diff_t'(qmag);
  end

  // ---------------- reconstruction and counters
  logic signed [8:0]  s9;
  logic signed [19:0] qs;
  logic signed [19:0] recon20;
  recon_t             recon_nxt;
  diff_t              coded11;
  logic [CW-1:0]      col_p1, w0, w_eff;
  logic [11:0]        row_p1, h0, h_eff;
  logic               wrap_col, wrap_row;

  always_comb begin
    s9        = {1'b0, s_eff};
    qs        = 20'(q_r) * 20'(s9);
    recon20   = qs + {{10{pred_r[9]}}, pred_r};
    recon_nxt = recon20[9:0];
    coded11   = q_r + MID_LEVEL;

    col_p1 = CW'(col_r) + CW'(1);
    w0     = CW'(width_r);
    if (width_r == '0)      w_eff = CW'(1);
    else if (w0 > MAX_W_C)  w_eff = MAX_W_C;
    else                    w_eff = w0;
    row_p1 = 12'(row_r) + 12'd1;
    h0     = 12'(height_r);
    if (height_r == '0)     h_eff = 12'd1;
    else if (h0 > MAX_H_C)  h_eff = MAX_H_C;
    else                    h_eff = h0;
    wrap_col = col_p1 >= w_eff;
    wrap_row = row_p1 >= h_eff;
  end

  // ---------------- line memory
  always_ff @(posedge clk) begin
    if (accept) up_r <= line_mem[col_r];
    if (fin_fire) line_mem[col_r] <= recon_nxt;
  end

  // ---------------- datapath registers
  always_ff @(posedge clk) begin
    if (accept) px_r <= in_pixel_value;
    if (state_r == ST_PRED) begin
      pred_r   <= pred[9:0];
      choice_r <= choice;
      m_r      <= n_mag[9:0];
      neg_r    <= n12[11];
    end
    if (state_r == ST_MUL) qa_r <= prod[RECIP_SHIFT +: 10];
    if (state_r == ST_CORR) q_r <= q_nxt;
    if (fin_fire) begin
      out_coded_value         <= coded11[9:0];
      out_chosen_predictor    <= choice_r;
      out_reconstructed_value <= recon_nxt;
      out_frame_end           <= wrap_col && wrap_row;
    end
  end

  // ---------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      upleft_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: if (accept) state_r <= ST_PRED;
        ST_PRED: state_r <= ST_MUL;
        ST_MUL:  state_r <= ST_CORR;
        ST_CORR: state_r <= ST_FIN;
        ST_FIN:  if (out_free) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase

      if (fin_fire) begin
        out_valid_r <= 1'b1;
        left_r      <= recon_nxt;
        upleft_r    <= up_r;
        if (wrap_col) begin
          col_r <= '0;
          row_r <= wrap_row ? 10'd0 : row_p1[9:0];
        end else begin
          col_r <= col_p1[AW-1:0];
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== design/dpcm_enc_chk.sv =====
module dpcm_enc_chk
  import dpcm_enc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [9:0] out_coded_value,
  input logic [1:0]        out_chosen_predictor,
  input logic signed [9:0] out_reconstructed_value,
  input logic              out_frame_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_coded_value) && $stable(out_chosen_predictor)
      && $stable(out_reconstructed_value) && $stable(out_frame_end))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second pixel taken while one is in flight");

  a_pred_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_chosen_predictor != MODE_COMP)
    else $error("competitive mode reported as predictor");

  a_recon_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reconstructed_value >= -10'sd128
      && out_reconstructed_value <= 10'sd383)
    else $error("reconstruction out of range");

endmodule

bind dpcm_image_encoder_core dpcm_enc_chk u_dpcm_enc_chk (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_valid                (in_valid),
  .in_stall                (in_stall),
  .out_valid               (out_valid),
  .out_stall               (out_stall),
  .out_coded_value         (out_coded_value),
  .out_chosen_predictor    (out_chosen_predictor),
  .out_reconstructed_value (out_reconstructed_value),
  .out_frame_end           (out_frame_end)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import dpcm_enc_pkg::*;

  localparam logic [2:0] CFG_SPARE_LO = 3'd4;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam int LINE_DEPTH   = DEF_MAX_WIDTH;
  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 150;

  typedef struct packed {
    recon_t     coded;
    logic [1:0] pred;
    recon_t     recon;
    logic       fe;
  } pix_result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [10:0] data;
    logic [7:0]  px;
    pix_result_t res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [10:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_pixel_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [9:0]  out_coded_value;
  logic [1:0]         out_chosen_predictor;
  logic signed [9:0]  out_reconstructed_value;
  logic               out_frame_end;

  dpcm_image_encoder_core i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_pixel_value          (in_pixel_value),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_coded_value         (out_coded_value),
    .out_chosen_predictor    (out_chosen_predictor),
    .out_reconstructed_value (out_reconstructed_value),
    .out_frame_end           (out_frame_end)
  );

  always #10 clk = ~clk;

  // encoder state mirror
  int          line_mem [LINE_DEPTH];
  int          line_filled = 0;
  int          left_r = 0;
  int          upleft_r = 0;
  int          col_cnt = 0;
  int          row_cnt = 0;
  logic [1:0]  m_mode = MODE_LEFT;
  logic [7:0]  m_step = 8'd1;
  logic [10:0] m_width = 11'(DEF_MAX_WIDTH);
  logic [10:0] m_height = 11'(MAX_HEIGHT);

  pix_result_t coded_q [$];
  dir_row_t    dir_tab [$];
  int          errors = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  bit          quiet = 1'b0;
  logic [7:0]  last_px = 8'd128;

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int eff_width();
    if (m_width == 0) return 1;
    if (m_width > LINE_DEPTH) return LINE_DEPTH;
    return int'(m_width);
  endfunction

  function automatic int eff_height();
    if (m_height == 0) return 1;
    if (m_height > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(m_height);
  endfunction

  function automatic pix_result_t encode_pixel(input logic [7:0] px);
    pix_result_t r;
    int x, s, w, h, col, up, p_left, p_avg, p_adapt, pred, e, n, d, q, recon;
    int a0, a1, a2;
    logic [1:0] choice;
    bit top, lead;
    x = int'(px);
    s = (m_step == 0) ? 1 : int'(m_step);
    w = eff_width();
    h = eff_height();
    col = col_cnt % LINE_DEPTH;
    top = (row_cnt == 0);
    lead = (col == 0);
    up = line_mem[col];
    p_left = lead ? int'(MID_LEVEL) : left_r;
    if (top && lead) begin
      p_avg = int'(MID_LEVEL);
      p_adapt = int'(MID_LEVEL);
    end else if (top) begin
      p_avg = (int'(MID_LEVEL) + left_r) / 2;
      p_adapt = left_r;
    end else if (lead) begin
      p_avg = (int'(MID_LEVEL) + up) / 2;
      p_adapt = up;
    end else begin
      p_avg = (left_r + up) / 2;
      p_adapt = (mag(up - upleft_r) < mag(left_r - upleft_r)) ? left_r : up;
    end
    if (m_mode == MODE_COMP) begin
      a0 = mag(x - p_left);
      a1 = mag(x - p_avg);
      a2 = mag(x - p_adapt);
      if (a0 < a1 && a0 < a2) choice = MODE_LEFT;
      else if (a1 < a2) choice = MODE_AVG;
      else choice = MODE_ADAPT;
    end else begin
      choice = m_mode;
    end
    pred = (choice == MODE_LEFT) ? p_left : ((choice == MODE_AVG) ? p_avg : p_adapt);
    // round half up: the division of 2*e + s by 2*s floors for a negative numerator
    e = x - pred;
    n = 2 * e + s;
    d = 2 * s;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    recon = q * s + pred;
    line_mem[col] = recon;
    if (col + 1 > line_filled) line_filled = col + 1;
    upleft_r = up;
    left_r = recon;
    r.fe = 1'b0;
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      if (row_cnt + 1 >= h) begin
        row_cnt = 0;
        r.fe = 1'b1;
      end else begin
        row_cnt = row_cnt + 1;
      end
    end else begin
      col_cnt = col_cnt + 1;
    end
    r.coded = recon_t'(q + int'(MID_LEVEL));
    r.pred = choice;
    r.recon = recon_t'(recon);
    return r;
  endfunction

  function automatic logic [7:0] next_pixel();
    int v;
    case ($urandom_range(0, 5))
      0: v = ($urandom_range(0, 1) == 1) ? 255 : 0;
      1, 2: v = int'(last_px) + int'($urandom_range(0, 8)) - 4;
      default: v = int'($urandom_range(0, 255));
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    last_px = v[7:0];
    return last_px;
  endfunction

  function automatic dir_row_t cfg_row(input logic [2:0] idx, input logic [10:0] data);
    dir_row_t t;
    t = '0;
    t.kind = ROW_CFG;
    t.idx = idx;
    t.data = data;
    return t;
  endfunction

  function automatic dir_row_t pix_row(input logic [7:0] px);
    dir_row_t t;
    t = '0;
    t.kind = ROW_PIX;
    t.px = px;
    return t;
  endfunction

  function automatic dir_row_t known_row(input logic [7:0] px, input recon_t coded,
                                         input logic [1:0] pred, input recon_t recon,
                                         input logic fe);
    dir_row_t t;
    t = '0;
    t.kind = ROW_PIX_KNOWN;
    t.px = px;
    t.res.coded = coded;
    t.res.pred = pred;
    t.res.recon = recon;
    t.res.fe = fe;
    return t;
  endfunction

  function automatic void add_row(input dir_row_t t);
    dir_tab.insert(dir_tab.size(), t);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 100)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_result();
    pix_result_t want;
    if (coded_q.size() == 0) begin
      report_mismatch("unexpected transaction", out_coded_value, 0);
      return;
    end
    want = coded_q.pop_front();
    if (out_coded_value !== want.coded)
      report_mismatch("coded_value", out_coded_value, want.coded);
    if (out_chosen_predictor !== want.pred)
      report_mismatch("chosen_predictor", out_chosen_predictor, want.pred);
    if (out_reconstructed_value !== want.recon)
      report_mismatch("reconstructed_value", out_reconstructed_value, want.recon);
    if (out_frame_end !== want.fe)
      report_mismatch("frame_end", out_frame_end, want.fe);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [10:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_MODE:   m_mode = data[1:0];
      CFG_STEP:   m_step = data[7:0];
      CFG_WIDTH:  m_width = data;
      CFG_HEIGHT: m_height = data;
      default: ;
    endcase
  endtask

  task automatic send_pixel(input logic [7:0] px, input bit known, input pix_result_t known_res);
    pix_result_t r;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_value <= px;
    do @(posedge clk); while (in_stall !== 1'b0);
    r = encode_pixel(px);
    if (known) r = known_res;
    coded_q.insert(coded_q.size(), r);
  endtask

  task automatic wait_drained();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (coded_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (3) @(posedge clk);
  endtask

  // result side: checks and back-pressure
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) check_result();
    if (hold_ack != hold_req) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #5000000;
    $display("dpcm_image_encoder_core verification failed");
    $finish;
  end

  initial begin
    dir_row_t    row;
    logic [10:0] data;
    logic [10:0] junk;
    int          w, h, rem_row, rem, count, rnd_sent, phase;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset: left mode, unit step
    add_row(known_row(8'd0, 10'sd0, MODE_LEFT, 10'sd0, 1'b0));
    add_row(known_row(8'd255, 10'sd383, MODE_LEFT, 10'sd255, 1'b0));
    add_row(known_row(8'd0, -10'sd127, MODE_LEFT, 10'sd0, 1'b0));
    add_row(cfg_row(CFG_SPARE_LO, 11'h7ff));
    add_row(cfg_row(CFG_SPARE_HI, 11'h555));
    add_row(pix_row(8'd9));
    // zero width while column is past it
    add_row(cfg_row(CFG_WIDTH, 11'd0));
    add_row(pix_row(8'd200));
    add_row(pix_row(8'd31));
    // zero height while row is past it
    add_row(cfg_row(CFG_HEIGHT, 11'd0));
    add_row(known_row(8'd77, 10'sd77, MODE_LEFT, 10'sd77, 1'b1));
    add_row(cfg_row(CFG_STEP, 11'd255));
    add_row(known_row(8'd255, 10'sd128, MODE_LEFT, 10'sd128, 1'b1));
    add_row(known_row(8'd0, 10'sd127, MODE_LEFT, -10'sd127, 1'b1));
    // zero step
    add_row(cfg_row(CFG_STEP, 11'd0));
    add_row(known_row(8'd200, 10'sd200, MODE_LEFT, 10'sd200, 1'b1));
    // oversize frame
    add_row(cfg_row(CFG_WIDTH, 11'd2047));
    add_row(cfg_row(CFG_HEIGHT, 11'd2047));
    add_row(cfg_row(CFG_MODE, 11'(MODE_AVG)));
    add_row(pix_row(8'd10));
    add_row(pix_row(8'd250));
    add_row(pix_row(8'd128));
    add_row(cfg_row(CFG_WIDTH, 11'd5));
    add_row(cfg_row(CFG_MODE, 11'(MODE_ADAPT)));
    add_row(pix_row(8'd0));
    add_row(pix_row(8'd255));
    add_row(pix_row(8'd60));
    add_row(pix_row(8'd70));
    add_row(cfg_row(CFG_STEP, 11'd7));
    add_row(cfg_row(CFG_MODE, 11'(MODE_COMP)));
    add_row(pix_row(8'd65));
    add_row(pix_row(8'd255));
    add_row(pix_row(8'd0));
    add_row(pix_row(8'd128));

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        write_reg(row.idx, row.data);
      end else begin
        send_pixel(row.px, row.kind == ROW_PIX_KNOWN, row.res);
      end
    end

    rnd_sent = 0;
    phase = 0;
    while (rnd_sent < RANDOM_ITEMS) begin
      wait_drained();
      junk = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'd0;
      if (phase == 0 || $urandom_range(0, 1) == 1)
        write_reg(CFG_MODE, (junk & ~11'h3) | 11'($urandom_range(0, 3)));
      if (phase == 0 || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 7))
          0: data = 11'd0;
          1: data = 11'd1;
          2: data = 11'd255;
          3, 4: data = 11'($urandom_range(1, 255));
          default: data = 11'($urandom_range(1, 16));
        endcase
        write_reg(CFG_STEP, (junk & ~11'hff) | data);
      end
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0: data = 11'd0;
          1: data = 11'($urandom_range(1000, 2047));
          2: data = 11'($urandom_range(13, 64));
          default: data = 11'($urandom_range(1, 12));
        endcase
        w = (data == 0) ? 1 : ((data > LINE_DEPTH) ? LINE_DEPTH : int'(data));
        // never let a later row read a line entry that was not yet written
        if (row_cnt != 0 && w > line_filled) data = 11'($urandom_range(1, line_filled));
        write_reg(CFG_WIDTH, data);
      end
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0: data = 11'd0;
          1: data = 11'($urandom_range(1000, 2047));
          default: data = 11'($urandom_range(1, 6));
        endcase
        write_reg(CFG_HEIGHT, data);
      end
      if ($urandom_range(0, 9) == 0)
        write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 11'($urandom));

      w = eff_width();
      h = eff_height();
      rem_row = (col_cnt < w) ? w - col_cnt : 1;
      rem = (row_cnt + 1 >= h) ? rem_row : rem_row + (h - row_cnt - 1) * w;
      if ($urandom_range(0, 9) < 7) count = (rem <= 150) ? rem : $urandom_range(20, 80);
      else count = $urandom_range(1, 30);
      if (phase == 3) begin
        hold_req++;
        count = 48;
      end
      if (count > RANDOM_ITEMS - rnd_sent) count = RANDOM_ITEMS - rnd_sent;
      if (rnd_sent > RANDOM_ITEMS - 120) quiet = 1'b1;
      repeat (count) begin
        send_pixel(next_pixel(), 1'b0, '0);
        rnd_sent++;
      end
      phase++;
    end

    wait_drained();
    if (coded_q.size() != 0) report_mismatch("results missing", coded_q.size(), 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("dpcm_image_encoder_core verification clean");
    end else begin
      $display("dpcm_image_encoder_core verification failed");
    end
    $finish;
  end

endmodule
